[rtl/twr_pkg.sv]
// Shared types and constants for the two-way ranging distance block.
`default_nettype none
package twr_pkg;

    localparam int TS_IN_BITS   = 40;
    localparam int TS_BITS_DEF  = 40;
    localparam int QUOT_BITS    = 12;
    localparam int N_PART       = 12;
    localparam int COEF_BITS    = 16;
    localparam logic [COEF_BITS-1:0] COEF_Q16 = 16'd30748;
    localparam int DIST_BITS    = 10;
    localparam logic [QUOT_BITS:0] MAX_DIST = 13'd1000;
    localparam int FIFO_DEPTH   = 2;

    typedef struct packed {
        logic [TS_IN_BITS-1:0] poll_tx_time;
        logic [TS_IN_BITS-1:0] poll_rx_time;
        logic [TS_IN_BITS-1:0] reply_tx_time;
        logic [TS_IN_BITS-1:0] reply_rx_time;
        logic [TS_IN_BITS-1:0] final_tx_time;
        logic [TS_IN_BITS-1:0] final_rx_time;
    } t_req;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance_cm;
        logic                 valid_res;
    } t_res;

endpackage
`default_nettype wire

[rtl/twr_front.sv]
// Front end: wrapped intervals, denominator and zero-denominator flag of one item.
`default_nettype none
module twr_front
    import twr_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TS_BITS_DEF
) (
    input  var t_req                        i_req,
    output logic [5*TIMESTAMP_BITS+2:0]     o_job
);
    localparam int T = TIMESTAMP_BITS;

    logic [T-1:0] tp, rp, tr, rr, tf, rf;
    logic [T-1:0] round1, reply1, round2, reply2;
    logic [T+1:0] den;
    logic         zero;

    assign tp = T'(i_req.poll_tx_time);
    assign rp = T'(i_req.poll_rx_time);
    assign tr = T'(i_req.reply_tx_time);
    assign rr = T'(i_req.reply_rx_time);
    assign tf = T'(i_req.final_tx_time);
    assign rf = T'(i_req.final_rx_time);

    assign round1 = rr - tp;
    assign reply1 = tr - rp;
    assign round2 = rf - tr;
    assign reply2 = tf - rr;

    assign den  = (T+2)'(round1) + (T+2)'(reply1) + (T+2)'(round2) + (T+2)'(reply2);
    assign zero = ~(|{round1, reply1, round2, reply2});

    assign o_job = {zero, den, round1, reply1, round2, reply2};
endmodule
`default_nettype wire

[rtl/twr_fifo.sv]
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none
module twr_fifo
    import twr_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(FIFO_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(FIFO_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/twr_back.sv]
// Back end: numerator by shared multiplier, bit-serial quotient, scaling and checks.
`default_nettype none
module twr_back
    import twr_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TS_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    input  wire [5*TIMESTAMP_BITS+2:0]   i_job,
    output logic                         o_pop,
    output logic                         o_done,
    output t_res                         o_res
);
    localparam int T  = TIMESTAMP_BITS;
    localparam int H  = (T + 1) / 2;
    localparam int AW = 2 * T + 3;
    localparam int IW = $clog2(QUOT_BITS);
    localparam int PW = QUOT_BITS + 1 + COEF_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_ABS   = 8'b0000_1000,
        S_CHK   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state           r_state;
    logic [3:0]       r_k;
    logic [IW-1:0]    r_i;
    logic             r_zero;
    logic [T+1:0]     r_den;
    logic [T-1:0]     r_round1, r_reply1, r_round2, r_reply2;
    logic [T-1:0]     r_m1, r_m2;
    logic             r_s1, r_s2;
    logic [2*H-1:0]   r_pp;
    logic [1:0]       r_pp_part;
    logic             r_pp_neg, r_ppv;
    logic [AW-1:0]    r_acc, r_rem, r_dsh;
    logic             r_neg, r_ovf;
    logic [QUOT_BITS-1:0] r_q;
    logic [PW-1:0]    r_prod;
    logic             r_done;
    t_res             r_res;

    logic [1:0]       prod_sel, part;
    logic [T-1:0]     opa, opb;
    logic             opsgn;
    logic [H-1:0]     a_h, b_h;
    logic [AW-1:0]    pp_ext;
    logic [QUOT_BITS:0] mag, scaled;
    logic             n_valid;
    logic             q_bit;

    assign prod_sel = r_k[3:2];
    assign part     = r_k[1:0];

    always_comb begin
        case (prod_sel)
            2'd0: begin
                opa = r_m1; opb = r_reply2; opsgn = r_s1;
            end
            2'd1: begin
                opa = r_m2; opb = r_reply1; opsgn = r_s2;
            end
            default: begin
                opa = r_m2; opb = r_m1; opsgn = r_s1 ^ r_s2;
            end
        endcase
    end

    assign a_h = part[1] ? H'(opa >> H) : H'(opa);
    assign b_h = part[0] ? H'(opb >> H) : H'(opb);

    always_comb begin
        case (r_pp_part)
            2'd0:    pp_ext = AW'(r_pp);
            2'd3:    pp_ext = AW'(r_pp) << (2 * H);
            default: pp_ext = AW'(r_pp) << H;
        endcase
    end

    assign q_bit  = (r_rem >= r_dsh);
    assign mag    = r_ovf ? (QUOT_BITS+1)'(1 << QUOT_BITS) : {1'b0, r_q};
    assign scaled = r_prod[PW-1:COEF_BITS];
    assign n_valid = !r_zero && !(r_neg && (scaled != '0)) && (scaled <= MAX_DIST);

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    {r_zero, r_den, r_round1, r_reply1, r_round2, r_reply2} <= i_job;
                    r_neg <= 1'b0;
                end
            end
            S_LOAD: begin
                r_s1  <= r_round1 < r_reply1;
                r_s2  <= r_round2 < r_reply2;
                r_m1  <= (r_round1 < r_reply1) ? r_reply1 - r_round1 : r_round1 - r_reply1;
                r_m2  <= (r_round2 < r_reply2) ? r_reply2 - r_round2 : r_round2 - r_reply2;
                r_acc <= '0;
            end
            S_MUL: begin
                r_pp      <= a_h * b_h;
                r_pp_part <= part;
                r_pp_neg  <= opsgn;
                if (r_ppv) begin
                    r_acc <= r_pp_neg ? r_acc - pp_ext : r_acc + pp_ext;
                end
            end
            S_ABS: begin
                r_neg <= r_acc[AW-1];
                r_rem <= r_acc[AW-1] ? AW'(0) - r_acc : r_acc;
                r_dsh <= AW'(r_den) << (QUOT_BITS - 1);
            end
            S_CHK: begin
                r_ovf <= r_rem >= (AW'(r_den) << QUOT_BITS);
            end
            S_DIV: begin
                if (q_bit) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[QUOT_BITS-2:0], q_bit};
                r_dsh <= r_dsh >> 1;
            end
            S_SCALE: begin
                r_prod <= PW'(mag) * PW'(COEF_Q16);
            end
            default: begin
            end
        endcase
        if (r_state == S_OUT) begin
            r_res.valid_res   <= n_valid;
            r_res.distance_cm <= n_valid ? DIST_BITS'(scaled) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_ppv   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_job[5*T+2] ? S_OUT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_ppv   <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_ppv <= (r_k < 4'(N_PART));
                    r_k   <= r_k + 1'b1;
                    if (r_k == 4'(N_PART)) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_i     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(QUOT_BITS - 1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/twr_distance_from_timestamps.sv]
// Top level of the double-sided two-way ranging distance block.
// An item of six timestamps is taken when start is high and busy is low; busy
// rises only when the two-entry queue behind the front end is full. Each item
// gives one result, shown for one cycle with o_done; the receiver cannot stall
// it. The back end works on one item at a time (it pops the queue only when idle):
// load, numerator on the shared half-width multiplier, absolute value, overflow
// check, the one-bit-per-cycle quotient, scaling and output; an item whose
// intervals are all zero goes straight to output.
`default_nettype none
module twr_distance_from_timestamps
    import twr_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TS_BITS_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  var t_req i_req,
    output logic     busy,
    output logic     o_done,
    output t_res     o_res
);
    localparam int JW = 5 * TIMESTAMP_BITS + 3;

    logic [JW-1:0] job_in, job_out;
    logic          full, empty, pop;

    twr_front #(.TIMESTAMP_BITS(TIMESTAMP_BITS)) u_front (
        .i_req (i_req),
        .o_job (job_in)
    );

    twr_fifo #(.WIDTH(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    twr_back #(.TIMESTAMP_BITS(TIMESTAMP_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    assign busy = full;
endmodule
`default_nettype wire

[rtl/twr_checker.sv]
// Port-level checks for the ranging distance block, bound to its top level.
`default_nettype none
module twr_checker
    import twr_pkg::*;
(
    input wire      i_clk,
    input wire      i_rst_n,
    input wire      start,
    input wire      busy,
    input wire      o_done,
    input var t_res o_res
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done && !busy)
        else $error("outputs active after reset");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.valid_res) |-> (o_res.distance_cm == '0))
        else $error("invalid result with nonzero distance");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.valid_res) |-> (o_res.distance_cm <= DIST_BITS'(MAX_DIST)))
        else $error("valid distance out of range");
endmodule

bind twr_distance_from_timestamps twr_checker u_chk (.*);
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the double-sided two-way ranging distance block.
`default_nettype none
module testbench;
    import twr_pkg::*;

    localparam int N_RANDOM  = 1800;
    localparam int CYC_LIMIT = 600000;
    localparam int TAIL      = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    twr_distance_from_timestamps dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_done(o_done), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    t_req pending_items[$];
    t_res expected_dist[$];
    int   n_accepted = 0;
    int   n_raised = 0;
    int   gap_left = 0;
    int   mismatches = 0;
    int   cycles = 0;
    bit   no_gaps = 1'b0;
    bit   stim_done = 1'b0;

    function automatic t_res distance_of(t_req r);
        logic [39:0] round1, reply1, round2, reply2;
        logic signed [127:0] d1, d2, rp1, rp2, den, num, mag, quot, scaled;
        t_res res;
        round1 = r.reply_rx_time - r.poll_tx_time;
        reply1 = r.reply_tx_time - r.poll_rx_time;
        round2 = r.final_rx_time - r.reply_tx_time;
        reply2 = r.final_tx_time - r.reply_rx_time;
        rp1 = {88'd0, reply1};
        rp2 = {88'd0, reply2};
        d1 = $signed({88'd0, round1}) - rp1;
        d2 = $signed({88'd0, round2}) - rp2;
        den = $signed({88'd0, round1}) + rp1 + $signed({88'd0, round2}) + rp2;
        res = '0;
        if (den == 0)
            return res;
        num = d1 * rp2 + d2 * rp1 + d2 * d1;
        mag = (num < 0) ? -num : num;
        quot = mag / den;
        if (quot > (128'sd1 <<< 20))
            quot = 128'sd1 <<< 20;
        scaled = (quot * 128'sd30748) >>> 16;
        if (num < 0 && scaled != 0)
            return res;
        if (scaled > 1000)
            return res;
        res.distance_cm = scaled[DIST_BITS-1:0];
        res.valid_res = 1'b1;
        return res;
    endfunction

    function automatic logic [39:0] rand_ts();
        return 40'({$urandom, $urandom});
    endfunction

    // build an exchange with a given flight time and small per-leg skews
    function automatic t_req exchange(int tof, int k1, int k2, int k3, int k4);
        t_req r;
        logic [39:0] reply1, reply2;
        reply1 = $urandom_range(0, 3) == 0 ? rand_ts() : 40'($urandom_range(0, 1 << 24));
        reply2 = $urandom_range(0, 3) == 0 ? rand_ts() : 40'($urandom_range(0, 1 << 24));
        r.poll_tx_time = rand_ts();
        r.poll_rx_time = rand_ts();
        r.reply_tx_time = r.poll_rx_time + reply1 + 40'(k1);
        r.reply_rx_time = r.poll_tx_time + reply1 + 40'(2 * tof + k2);
        r.final_tx_time = r.reply_rx_time + reply2 + 40'(k3);
        r.final_rx_time = r.reply_tx_time + reply2 + 40'(2 * tof + k4);
        return r;
    endfunction

    initial begin
        t_req r;
        // zero intervals: zero denominator
        r = '0;
        pending_items.push_back(r);
        r = '1;
        pending_items.push_back(r);
        r = {6{40'h55_5555_5555}};
        pending_items.push_back(r);
        // one or two intervals at the top of the range, the others small
        r = '0;
        r.reply_rx_time = '1; r.reply_tx_time = '1;
        pending_items.push_back(r);
        r = '1;
        r.poll_tx_time = '0; r.final_tx_time = '0;
        pending_items.push_back(r);
        for (int i = 0; i < 6; i++) begin
            pending_items.push_back(exchange(0, 0, 0, 0, 0));
            pending_items.push_back(exchange(2131 + i, 0, 0, 0, 0));
            pending_items.push_back(exchange(i, 0, -2 - i, 0, -2 - i));
        end
        pending_items.push_back(exchange(1 << 20, 0, 0, 0, 0));
        pending_items.push_back(exchange(0, 5, -3000, 1, -3000));
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    r = {rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts()};
                    pending_items.push_back(r);
                end
                1: pending_items.push_back(exchange($urandom_range(0, 1 << 22),
                    $urandom_range(0, 9) - 5, $urandom_range(0, 9) - 5,
                    $urandom_range(0, 9) - 5, $urandom_range(0, 9) - 5));
                2: pending_items.push_back(exchange($urandom_range(0, 3), 0,
                    -$urandom_range(0, 8), 0, -$urandom_range(0, 8)));
                default: pending_items.push_back(exchange($urandom_range(0, 2300),
                    $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                    $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20));
            endcase
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && n_accepted != n_raised) begin
                // hold
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (stim_done && pending_items.size() > 0) begin
                start <= 1'b1;
                i_req <= pending_items.pop_front();
                n_raised <= n_raised + 1;
                if ($urandom_range(0, 199) == 0)
                    no_gaps <= ~no_gaps;
                gap_left <= no_gaps ? 0 : $urandom_range(0, 19);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            expected_dist.push_back(distance_of(i_req));
            n_accepted <= n_accepted + 1;
        end
        if (i_rst_n && o_done) begin
            if (expected_dist.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result: dist %0d valid %0b",
                             o_res.distance_cm, o_res.valid_res);
            end else begin
                want = expected_dist.pop_front();
                if (o_res.distance_cm !== want.distance_cm
                    || o_res.valid_res !== want.valid_res) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp dist %0d valid %0b, got dist %0d valid %0b",
                                 want.distance_cm, want.valid_res,
                                 o_res.distance_cm, o_res.valid_res);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending_items.size() > 0 || start || expected_dist.size() > 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        #1;
        if (mismatches == 0 && expected_dist.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        wait (cycles >= CYC_LIMIT);
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
